>>> rtl/scre_pkg.sv
package scre_pkg;

  // Request kinds
  localparam logic KIND_START = 1'b0;
  localparam logic KIND_TICK  = 1'b1;

  // Response kinds
  localparam logic [1:0] RESP_NONE = 2'd0;
  localparam logic [1:0] RESP_R1   = 2'd1;
  localparam logic [1:0] RESP_R2   = 2'd2;
  localparam logic [1:0] RESP_R3   = 2'd3;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BUSY    = 2'd1,
    ST_CRC_ERR = 2'd2,
    ST_TIMEOUT = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_SEND = 2'd1,
    PH_WAIT = 2'd2,
    PH_RECV = 2'd3
  } phase_t;

  localparam int          FRAME_BITS  = 48;
  localparam int          HEAD_BITS   = 40;   // start, dir, index, argument
  localparam int          BYTE_BITS   = 8;
  localparam int          CRC_BYTES   = 5;
  localparam int          SHORT_RESP  = 6;
  localparam int          LONG_RESP   = 17;
  localparam logic [6:0]  CRC_POLY    = 7'h09;
  localparam logic [7:0]  LIMIT_RESET = 8'd101;
  localparam int          Q_DEPTH     = 3;

  typedef struct packed {
    logic        kind;
    logic [5:0]  cmd_index;
    logic [31:0] argument;
    logic [1:0]  response_kind;
    logic        cmd_sample;
  } item_t;

  typedef struct packed {
    logic        cmd_drive;
    logic        drive_enable;
    logic        byte_valid;
    logic [7:0]  byte_value;
    logic [4:0]  byte_number;
    logic        done_res;
    status_t     status;
  } result_t;

  function automatic logic [6:0] crc7_bit(input logic [6:0] crc, input logic din);
    logic fb;
    fb = din ^ crc[6];
    return {crc[5:0], 1'b0} ^ (fb ? CRC_POLY : 7'd0);
  endfunction

endpackage

>>> rtl/scre_engine.sv
module scre_engine (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  input  scre_pkg::item_t   item,
  input  logic [7:0]        limit,
  output scre_pkg::result_t res
);
  import scre_pkg::*;

  phase_t             phase, phase_next;
  logic [HEAD_BITS-1:0] tx_shift, tx_shift_next;
  logic [5:0]         bit_count, bit_count_next;
  logic [6:0]         crc_reg, crc_reg_next;
  logic [7:0]         rx_byte, rx_byte_next;
  logic [4:0]         rx_byte_count, rx_byte_count_next;
  logic [7:0]         wait_count, wait_count_next;
  logic [1:0]         kind_latched, kind_latched_next;
  logic               busy_flag, busy_flag_next;

  logic       tick;
  logic       last_bit;
  logic       byte_end;
  logic       last_byte;
  logic       timed_out;
  logic [4:0] total;
  logic [7:0] rx_new;
  logic [6:0] crc_rx;
  logic       busy_new;

  assign tick      = item.kind == KIND_TICK;
  assign last_bit  = bit_count == 6'(FRAME_BITS - 1);
  assign byte_end  = bit_count == 6'(BYTE_BITS - 1);
  assign total     = (kind_latched == RESP_R2) ? 5'(LONG_RESP) : 5'(SHORT_RESP);
  assign last_byte = rx_byte_count == total - 5'd1;
  assign timed_out = wait_count >= limit;
  assign rx_new    = {rx_byte[6:0], item.cmd_sample};
  assign crc_rx    = (rx_byte_count < 5'(CRC_BYTES)) ? crc7_bit(crc_reg, item.cmd_sample)
                                                     : crc_reg;
  assign busy_new  = busy_flag | ((kind_latched == RESP_R3) && (rx_byte_count == 5'd1) &&
                                  !rx_new[7]);

  // Sequencer
  always_comb begin
    phase_next = phase;
    if (!tick) begin
      phase_next = PH_SEND;
    end else begin
      unique case (phase)
        PH_IDLE: phase_next = PH_IDLE;
        PH_SEND: begin
          if (last_bit) begin
            phase_next = (kind_latched == RESP_NONE) ? PH_IDLE : PH_WAIT;
          end
        end
        PH_WAIT: begin
          if (!item.cmd_sample) begin
            phase_next = PH_RECV;
          end else if (timed_out) begin
            phase_next = PH_IDLE;
          end
        end
        PH_RECV: begin
          if (byte_end && last_byte) begin
            phase_next = PH_IDLE;
          end
        end
        default: phase_next = PH_IDLE;
      endcase
    end
  end

  // Datapath and result
  always_comb begin
    tx_shift_next      = tx_shift;
    bit_count_next     = bit_count;
    crc_reg_next       = crc_reg;
    rx_byte_next       = rx_byte;
    rx_byte_count_next = rx_byte_count;
    wait_count_next    = wait_count;
    kind_latched_next  = kind_latched;
    busy_flag_next     = busy_flag;
    res                = '0;
    res.cmd_drive      = 1'b1;
    res.status         = ST_OK;
    if (!tick) begin
      tx_shift_next      = {2'b01, item.cmd_index, item.argument};
      bit_count_next     = '0;
      crc_reg_next       = '0;
      rx_byte_next       = '0;
      rx_byte_count_next = '0;
      wait_count_next    = '0;
      kind_latched_next  = item.response_kind;
      busy_flag_next     = 1'b0;
    end else begin
      unique case (phase)
        PH_IDLE: begin
        end
        PH_SEND: begin
          // Head bits feed the CRC; afterwards the CRC shifts out with a
          // trailing one that becomes the end bit.
          res.drive_enable = 1'b1;
          if (bit_count < 6'(HEAD_BITS)) begin
            res.cmd_drive = tx_shift[HEAD_BITS-1];
            crc_reg_next  = crc7_bit(crc_reg, tx_shift[HEAD_BITS-1]);
            tx_shift_next = {tx_shift[HEAD_BITS-2:0], 1'b0};
          end else begin
            res.cmd_drive = crc_reg[6];
            crc_reg_next  = {crc_reg[5:0], 1'b1};
          end
          bit_count_next = bit_count + 6'd1;
          if (last_bit) begin
            bit_count_next  = '0;
            wait_count_next = '0;
            if (kind_latched == RESP_NONE) begin
              res.done_res = 1'b1;
            end
          end
        end
        PH_WAIT: begin
          if (!item.cmd_sample) begin
            rx_byte_next       = '0;
            bit_count_next     = 6'd1;
            rx_byte_count_next = '0;
            crc_reg_next       = '0;
            busy_flag_next     = 1'b0;
          end else if (timed_out) begin
            res.done_res = 1'b1;
            res.status   = ST_TIMEOUT;
          end else begin
            wait_count_next = wait_count + 8'd1;
          end
        end
        PH_RECV: begin
          crc_reg_next   = crc_rx;
          rx_byte_next   = rx_new;
          bit_count_next = bit_count + 6'd1;
          if (byte_end) begin
            res.byte_valid     = 1'b1;
            res.byte_value     = rx_new;
            res.byte_number    = rx_byte_count;
            busy_flag_next     = busy_new;
            rx_byte_count_next = rx_byte_count + 5'd1;
            bit_count_next     = '0;
            if (last_byte) begin
              res.done_res = 1'b1;
              if ((kind_latched == RESP_R3) && busy_new) begin
                res.status = ST_BUSY;
              end else if ((kind_latched == RESP_R1) && (rx_new != {crc_rx, 1'b1})) begin
                res.status = ST_CRC_ERR;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
    end else if (item_valid) begin
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid) begin
      tx_shift      <= tx_shift_next;
      bit_count     <= bit_count_next;
      crc_reg       <= crc_reg_next;
      rx_byte       <= rx_byte_next;
      rx_byte_count <= rx_byte_count_next;
      wait_count    <= wait_count_next;
      kind_latched  <= kind_latched_next;
      busy_flag     <= busy_flag_next;
    end
  end

endmodule

>>> rtl/scre_out_queue.sv
module scre_out_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  scre_pkg::result_t din,
  input  logic              pop,
  output scre_pkg::result_t dout,
  output logic [$clog2(scre_pkg::Q_DEPTH+1)-1:0] count
);
  import scre_pkg::*;

  localparam int PTR_W = $clog2(Q_DEPTH);
  localparam int CNT_W = $clog2(Q_DEPTH + 1);

  result_t            slots [Q_DEPTH];
  logic [PTR_W-1:0]   wr_ptr, rd_ptr;

  assign dout = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      count <= count + CNT_W'(push) - CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= din;
    end
  end

endmodule

>>> rtl/sd_command_response_engine.sv
// Channel  Handshake            Payload
// in       in_valid / in_stall  kind, cmd_index, argument, response_kind, cmd_sample
// out      out_valid/ out_stall cmd_drive, drive_enable, byte_valid, byte_value,
//                               byte_number, done_res, status
// cfg      APB write/read       start_timeout_limit at byte address 0
//
// One request per clock while in_stall is low; each request gives exactly one result
// (input register, then engine logic into a three-slot output queue).
// The engine does all of one request's work in a single pass of logic.
// in_stall rises when the input register and the queue together hold three.
// rst is synchronous and clears the phase, the queue and the timeout limit (101).
module sd_command_response_engine (
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        kind,
  input  logic [5:0]  cmd_index,
  input  logic [31:0] argument,
  input  logic [1:0]  response_kind,
  input  logic        cmd_sample,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        cmd_drive,
  output logic        drive_enable,
  output logic        byte_valid,
  output logic [7:0]  byte_value,
  output logic [4:0]  byte_number,
  output logic        done_res,
  output logic [1:0]  status,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import scre_pkg::*;

  localparam int         CNT_W     = $clog2(Q_DEPTH + 1);
  localparam int         OCC_W     = $clog2(Q_DEPTH + 2);
  localparam logic       REG_LIMIT = 1'b0;  // word index of start_timeout_limit

  logic                  in_accept;
  logic                  item_valid;
  item_t                 item;
  logic [7:0]            limit;
  result_t               eng_res;
  result_t               out_res;
  logic                  q_pop;
  logic [CNT_W-1:0]      q_count;
  logic [OCC_W-1:0]      occupancy;
  logic                  cfg_write;

  // ---------------------------------------------------------------------------
  // Configuration: one 8-bit register, written during the APB access phase.
  // ---------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= LIMIT_RESET;
    end else if (cfg_write && (paddr[2] == REG_LIMIT)) begin
      limit <= pwdata[7:0];
    end
  end

  assign prdata = (paddr[2] == REG_LIMIT) ? {24'd0, limit} : 32'd0;

  // ---------------------------------------------------------------------------
  // Input register. Occupancy counts the queue plus the request in flight, so
  // the queue can never overflow and in_stall depends on registers only.
  // ---------------------------------------------------------------------------
  assign occupancy = OCC_W'(q_count) + OCC_W'(item_valid);
  assign in_stall  = occupancy >= OCC_W'(Q_DEPTH);
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      item_valid <= in_accept;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      item.kind          <= kind;
      item.cmd_index     <= cmd_index;
      item.argument      <= argument;
      item.response_kind <= response_kind;
      item.cmd_sample    <= cmd_sample;
    end
  end

  // ---------------------------------------------------------------------------
  // Frame / response engine: state advances on each registered request.
  // ---------------------------------------------------------------------------
  scre_engine u_engine (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .limit      (limit),
    .res        (eng_res)
  );

  // ---------------------------------------------------------------------------
  // Output queue decouples the result side from the request side.
  // ---------------------------------------------------------------------------
  assign q_pop = out_valid && !out_stall;

  scre_out_queue u_out_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (item_valid),
    .din   (eng_res),
    .pop   (q_pop),
    .dout  (out_res),
    .count (q_count)
  );

  assign out_valid    = q_count != '0;
  assign cmd_drive    = out_res.cmd_drive;
  assign drive_enable = out_res.drive_enable;
  assign byte_valid   = out_res.byte_valid;
  assign byte_value   = out_res.byte_value;
  assign byte_number  = out_res.byte_number;
  assign done_res     = out_res.done_res;
  assign status       = out_res.status;

`ifndef SYNTH
  // Queue never receives a push while full and not draining.
  assert property (@(posedge clk) disable iff (rst)
    !(item_valid && (q_count == CNT_W'(Q_DEPTH)) && !q_pop))
    else $error("output queue overflow");

  // A request accepted now is always written into the queue next cycle.
  assert property (@(posedge clk) disable iff (rst)
    in_accept |=> item_valid)
    else $error("accepted request lost");

  // While the host drives the line, no response byte or timeout can appear.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && drive_enable) |-> (!byte_valid && (status != ST_TIMEOUT)))
    else $error("response data during command drive");

  // Idle byte fields read as zero.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !byte_valid) |-> ((byte_value == 8'd0) && (byte_number == 5'd0)))
    else $error("byte fields nonzero without a byte");
`endif

endmodule

>>> tb/tb_sd_command_response_engine.sv
`timescale 1ns / 1ps

// Self-checking bench for the SD CMD-line engine.
// Every request (a command start or one SD clock tick) produces exactly one result,
// so the expected-result queue gets one entry per accepted request.
module tb_sd_command_response_engine;
  import scre_pkg::*;

  localparam int         CYCLE_LIMIT = 600000;
  localparam int         PHASE_ITEMS = 60;    // random requests per limit setting
  localparam int         LONG_HOLD   = 90;    // receiver hold-off, in cycles
  localparam logic [2:0] LIMIT_ADDR  = 3'd0;  // start_timeout_limit

  logic        clk;
  logic        rst = 1'b1;

  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        kind;
  logic [5:0]  cmd_index;
  logic [31:0] argument;
  logic [1:0]  response_kind;
  logic        cmd_sample;

  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        cmd_drive;
  logic        drive_enable;
  logic        byte_valid;
  logic [7:0]  byte_value;
  logic [4:0]  byte_number;
  logic        done_res;
  logic [1:0]  status;

  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  sd_command_response_engine dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .kind          (kind),
    .cmd_index     (cmd_index),
    .argument      (argument),
    .response_kind (response_kind),
    .cmd_sample    (cmd_sample),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .cmd_drive     (cmd_drive),
    .drive_enable  (drive_enable),
    .byte_valid    (byte_valid),
    .byte_value    (byte_value),
    .byte_number   (byte_number),
    .done_res      (done_res),
    .status        (status),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // Request currently offered; payload pins follow it.
  item_t drv_item = '0;
  assign kind          = drv_item.kind;
  assign cmd_index     = drv_item.cmd_index;
  assign argument      = drv_item.argument;
  assign response_kind = drv_item.response_kind;
  assign cmd_sample    = drv_item.cmd_sample;

  item_t   req_q[$];        // requests waiting to be offered
  result_t line_result_q[$]; // predicted results, oldest first
  result_t want_res;

  int  queued_cnt = 0;
  int  taken_cnt = 0;
  int  res_cnt = 0;
  int  err_cnt = 0;
  int  cyc_cnt = 0;
  bit  req_taken = 1'b0;
  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  bit  hold_kick = 1'b0;
  int  hold_left = 0;

  // Shadow of the engine state and its one register.
  logic [7:0]  lim_cfg = LIMIT_RESET;
  phase_t      ph = PH_IDLE;
  logic [47:0] tx_frame = '0;
  logic [5:0]  nbits = '0;
  logic [6:0]  crc_acc = '0;
  logic [7:0]  rx_sh = '0;
  logic [4:0]  rx_cnt = '0;
  logic [7:0]  wait_cnt = '0;
  logic [1:0]  rk_lat = '0;
  logic        busy_seen = 1'b0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // CRC7, x^7 + x^3 + 1, one bit at a time, MSB first.
  function automatic logic [6:0] crc7_step(input logic [6:0] acc, input logic b);
    logic [6:0] nxt;
    nxt = {acc[5:0], 1'b0};
    if (b ^ acc[6]) nxt = nxt ^ CRC_POLY;
    return nxt;
  endfunction

  // Advance the shadow engine by one request and return what the CMD line does.
  function automatic result_t next_line_result(input item_t it);
    result_t    r;
    logic [39:0] head;
    logic [6:0]  c;
    int          total;
    int          i;
    r = '0;
    r.cmd_drive = 1'b1;   // line idles high whenever the host isn't driving
    r.status = ST_OK;
    if (it.kind == KIND_START) begin
      // a start always wins, even over a command in flight
      head = {2'b01, it.cmd_index, it.argument};
      c = 7'd0;
      for (i = 39; i >= 0; i--) c = crc7_step(c, head[i]);
      tx_frame = {head, c, 1'b1};
      nbits = '0;
      crc_acc = '0;
      rx_sh = '0;
      rx_cnt = '0;
      wait_cnt = '0;
      rk_lat = it.response_kind;
      busy_seen = 1'b0;
      ph = PH_SEND;
    end else begin
      case (ph)
        PH_SEND: begin
          r.cmd_drive = tx_frame[47];
          r.drive_enable = 1'b1;
          tx_frame = tx_frame << 1;
          nbits = nbits + 6'd1;
          if (nbits >= FRAME_BITS) begin
            nbits = '0;
            wait_cnt = '0;
            if (rk_lat == RESP_NONE) begin
              r.done_res = 1'b1;   // done on the end bit
              ph = PH_IDLE;
            end else begin
              ph = PH_WAIT;
            end
          end
        end
        PH_WAIT: begin
          if (!it.cmd_sample) begin
            // start bit is bit 7 of byte 0 and feeds the CRC
            rx_sh = '0;
            nbits = 6'd1;
            rx_cnt = '0;
            crc_acc = crc7_step(7'd0, 1'b0);
            busy_seen = 1'b0;
            ph = PH_RECV;
          end else if (wait_cnt >= lim_cfg) begin
            r.done_res = 1'b1;
            r.status = ST_TIMEOUT;
            ph = PH_IDLE;
          end else begin
            wait_cnt = wait_cnt + 8'd1;
          end
        end
        PH_RECV: begin
          total = (rk_lat == RESP_R2) ? LONG_RESP : SHORT_RESP;
          if (rx_cnt < CRC_BYTES) crc_acc = crc7_step(crc_acc, it.cmd_sample);
          rx_sh = {rx_sh[6:0], it.cmd_sample};
          nbits = nbits + 6'd1;
          if (nbits >= BYTE_BITS) begin
            r.byte_valid = 1'b1;
            r.byte_value = rx_sh;
            r.byte_number = rx_cnt;
            if (rk_lat == RESP_R3 && rx_cnt == 5'd1 && !rx_sh[7]) busy_seen = 1'b1;
            rx_cnt = rx_cnt + 5'd1;
            nbits = '0;
            if (rx_cnt >= total) begin
              r.done_res = 1'b1;
              if (rk_lat == RESP_R3 && busy_seen) r.status = ST_BUSY;
              else if (rk_lat == RESP_R1 && rx_sh != {crc_acc, 1'b1}) r.status = ST_CRC_ERR;
              ph = PH_IDLE;
            end
          end
        end
        default: ;  // idle tick: sample ignored
      endcase
    end
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    err_cnt++;
    $display("ERROR result %0d: %s", res_cnt, msg);
  endtask

  task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want) report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
  endtask

  function automatic item_t mk_tick(input logic s);
    item_t t;
    t.kind = KIND_TICK;
    // unused fields still toggle
    t.cmd_index = 6'($urandom());
    t.argument = $urandom();
    t.response_kind = 2'($urandom());
    t.cmd_sample = s;
    return t;
  endfunction

  function automatic item_t mk_start(input logic [5:0] idx, input logic [31:0] arg,
                                     input logic [1:0] rk);
    item_t t;
    t.kind = KIND_START;
    t.cmd_index = idx;
    t.argument = arg;
    t.response_kind = rk;
    t.cmd_sample = 1'($urandom_range(0, 1));
    return t;
  endfunction

  task automatic add_req(input item_t it);
    req_q.push_back(it);
    queued_cnt++;
  endtask

  // Queue one full command: start, 48 frame ticks, then (if a response is due)
  // `hi` high samples and a response, or limit+1 highs for a timeout.
  // cut > 0 keeps only the first cut requests, so the next start abandons it.
  task automatic queue_command(input logic [5:0] idx, input logic [31:0] arg,
                               input logic [1:0] rk, input int hi, input bit tmo,
                               input bit crc_good, input bit r3_busy, input int cut);
    item_t      seq[$];
    logic [7:0] rb [0:16];
    logic [6:0] c;
    int         nb;
    int         n;
    seq.push_back(mk_start(idx, arg, rk));
    repeat (FRAME_BITS) seq.push_back(mk_tick(1'($urandom_range(0, 1))));
    if (rk != RESP_NONE) begin
      if (tmo) begin
        repeat (int'(lim_cfg) + 1) seq.push_back(mk_tick(1'b1));
      end else begin
        repeat (hi) seq.push_back(mk_tick(1'b1));
        nb = (rk == RESP_R2) ? LONG_RESP : SHORT_RESP;
        for (int i = 0; i < nb; i++) rb[i] = 8'($urandom());
        rb[0][7] = 1'b0;
        if (rk == RESP_R3) rb[1][7] = !r3_busy;   // busy reads as bit 7 clear
        if (rk == RESP_R1) begin
          c = 7'd0;
          for (int i = 0; i < CRC_BYTES * BYTE_BITS; i++) c = crc7_step(c, rb[i / 8][7 - i % 8]);
          rb[SHORT_RESP - 1] = {c, 1'b1};
          if (!crc_good) rb[SHORT_RESP - 1][$urandom_range(0, 7)] ^= 1'b1;
        end
        for (int i = 0; i < nb * BYTE_BITS; i++) seq.push_back(mk_tick(rb[i / 8][7 - i % 8]));
      end
    end
    n = (cut > 0 && cut < seq.size()) ? cut : seq.size();
    for (int i = 0; i < n; i++) add_req(seq[i]);
  endtask

  // Everything sent has come back; the engine output queue is empty too.
  task automatic wait_drained;
    while (taken_cnt != queued_cnt || line_result_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // APB write of the timeout limit, then read it back.
  task automatic set_limit(input logic [7:0] v);
    logic [31:0] w;
    w = $urandom();
    w[7:0] = v;   // upper bits are don't-care on write
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= LIMIT_ADDR;
    pwdata <= w;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    lim_cfg = v;
    @(negedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {24'd0, v})
      report_mismatch($sformatf("limit readback got 0x%0h want 0x%0h", prdata, v));
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Request driver: holds an offered request until taken, then maybe idles.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || req_taken) begin
      if (req_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        drv_item <= req_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    req_taken = 1'b0;
  end

  // Request accepted: predict its result right away.
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      line_result_q.push_back(next_line_result(drv_item));
      taken_cnt++;
      req_taken = 1'b1;
    end
  end

  // Result-side stall: random, or a long hold-off when kicked.
  always @(negedge clk) begin
    if (hold_kick) begin
      hold_left = LONG_HOLD;
      hold_kick = 1'b0;
    end
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // Result checker.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (line_result_q.size() == 0) begin
        report_mismatch("result with nothing expected");
      end else begin
        want_res = line_result_q.pop_front();
        check_field("cmd_drive", 8'(cmd_drive), 8'(want_res.cmd_drive));
        check_field("drive_enable", 8'(drive_enable), 8'(want_res.drive_enable));
        check_field("byte_valid", 8'(byte_valid), 8'(want_res.byte_valid));
        check_field("byte_value", byte_value, want_res.byte_value);
        check_field("byte_number", 8'(byte_number), 8'(want_res.byte_number));
        check_field("done_res", 8'(done_res), 8'(want_res.done_res));
        check_field("status", 8'(status), 8'(want_res.status));
      end
      res_cnt++;
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cyc_cnt++;
    if (cyc_cnt > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    logic [7:0]  lims [0:5];
    logic [5:0]  idx;
    logic [31:0] arg;
    logic [1:0]  rk;
    item_t       noise;
    int          sel;
    int          hi;
    int          start_cnt;
    int          cmd_cnt;
    bit          kick_pending;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // sender mostly busy, receiver mostly stalling
    send_idle_pct = 14;
    recv_idle_pct = 65;

    // --- directed, reset limit (101) ---
    add_req(mk_tick(1'b0));   // ticks while idle do nothing
    add_req(mk_tick(1'b1));
    queue_command(6'd0, 32'd0, RESP_NONE, 0, 0, 1, 0, 0);
    queue_command(6'h3f, 32'hffff_ffff, RESP_R1, 0, 0, 1, 0, 20);  // abandoned mid-frame
    queue_command(6'($urandom()), $urandom(), RESP_R1, 0, 0, 1, 0, 0);  // good CRC
    queue_command(6'($urandom()), $urandom(), RESP_R1, 3, 0, 0, 0, 0);  // bad CRC
    queue_command(6'($urandom()), $urandom(), RESP_R3, 2, 0, 1, 1, 0);  // card busy
    queue_command(6'($urandom()), $urandom(), RESP_R2, 0, 1, 1, 0, 0);  // timeout
    // receiver holds off while the directed requests keep coming
    hold_kick = 1'b1;
    wait_drained();

    // limit of zero: first high sample while waiting times out
    set_limit(8'd0);
    queue_command(6'($urandom()), $urandom(), RESP_R3, 0, 1, 1, 0, 0);
    // start bit right at the limit
    queue_command(6'($urandom()), $urandom(), RESP_R1, 0, 0, 1, 0, 0);
    wait_drained();

    // --- random phases, one limit setting each ---
    lims[0] = 8'd1;
    lims[1] = 8'd255;
    lims[2] = 8'($urandom_range(1, 255));
    lims[3] = 8'd2;
    lims[4] = 8'($urandom_range(1, 255));
    lims[5] = LIMIT_RESET;
    cmd_cnt = 0;
    for (int p = 0; p < 6; p++) begin
      if (p == 2) begin
        send_idle_pct = 65;
        recv_idle_pct = 14;
      end
      if (p == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      wait_drained();
      set_limit(lims[p]);
      kick_pending = (p == 1 || p == 4);
      start_cnt = queued_cnt;
      while (queued_cnt - start_cnt < PHASE_ITEMS) begin
        if ($urandom_range(0, 9) == 0) begin
          // junk requests between commands
          repeat ($urandom_range(1, 3)) begin
            noise.kind = 1'($urandom_range(0, 1));
            noise.cmd_index = 6'($urandom());
            noise.argument = $urandom();
            noise.response_kind = 2'($urandom());
            noise.cmd_sample = 1'($urandom_range(0, 1));
            add_req(noise);
          end
        end
        rk = 2'($urandom_range(0, 3));
        idx = 6'($urandom_range(0, 63));
        case ($urandom_range(0, 7))
          0: arg = 32'd0;
          1: arg = 32'hffff_ffff;
          default: arg = $urandom();
        endcase
        // mostly a quick start bit; sometimes right at the limit or a timeout
        sel = int'($urandom_range(0, 9));
        hi = int'($urandom_range(0, (lim_cfg < 12) ? lim_cfg : 12));
        if (sel == 7) hi = int'(lim_cfg);
        if (sel == 9) hi = int'($urandom_range(0, lim_cfg));
        queue_command(idx, arg, rk, hi, sel == 8, $urandom_range(0, 3) != 0,
                      1'($urandom_range(0, 1)),
                      ($urandom_range(0, 9) == 0) ? int'($urandom_range(1, 150)) : 0);
        if (kick_pending && req_q.size() > 30) begin
          // receiver holds off while the sender keeps pushing: fills the engine
          hold_kick = 1'b1;
          kick_pending = 1'b0;
        end
        cmd_cnt++;
        if (cmd_cnt % 7 == 0) wait_drained();  // sender pause until all results are in
      end
    end

    wait_drained();
    repeat (6) @(negedge clk);
    if (err_cnt == 0 && line_result_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/scre_pkg.sv
rtl/scre_engine.sv
rtl/scre_out_queue.sv
rtl/sd_command_response_engine.sv
tb/tb_sd_command_response_engine.sv
